[rtl/itrd_pkg.sv]
// Package for the integer to radix digits block: shared types, constants
// and the small digit helper functions.
// No dependencies; used by every module of the block.
package itrd_pkg;

   // Widths fixed by the item fields and the register
   localparam int DEFAULT_VALUE_BITS = 31;
   localparam int BASE_W             = 6;
   localparam int CHAR_W             = 7;

   // Register reset and radix limits
   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

   // ASCII codes: '0' and the offset that maps digit 10 onto 'A'
   localparam logic [CHAR_W-1:0] ASCII_ZERO          = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_LETTER_OFFSET = 7'd55;
   localparam logic [BASE_W-1:0] DECIMAL_DIGITS      = 6'd10;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_BIT,
      ST_DIV_STORE,
      ST_READ,
      ST_LOAD_OUT
   } itrd_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;      // take a new item into the quotient register
      logic step;      // one restoring division step
      logic store;     // write the finished digit, start the next division
      logic read;      // read the digit store at the emission index
      logic load_out;  // move the read digit into the output register
   } itrd_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic bit_last;   // last division step of this digit
      logic quot_zero;  // quotient is zero
      logic cnt_full;   // digit store about to be full
      logic cnt_one;    // one digit left to emit
      logic out_free;   // output register empty or being taken
   } itrd_sts_type;

   // Register value clamped into the legal radix range
   function automatic logic [BASE_W-1:0] effective_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      r = b;
      if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (b > BASE_MAX) begin
         r = BASE_MAX;
      end
      return r;
   endfunction

   // Digit value to ASCII character
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [BASE_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DECIMAL_DIGITS) begin
         c = ASCII_ZERO + {1'b0, d};
      end else begin
         c = ASCII_LETTER_OFFSET + {1'b0, d};
      end
      return c;
   endfunction

endpackage

[rtl/itrd_ctrl.sv]
// Controller of the integer to radix digits block: sequences the bit-serial
// division per digit and the digit emission.
// Depends on itrd_pkg.
module itrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  itrd_pkg::itrd_sts_type sts,
   output itrd_pkg::itrd_cmd_type cmd
);

   itrd_pkg::itrd_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itrd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itrd_pkg::ST_IDLE: begin
            if (req_valid) state_in = itrd_pkg::ST_DIV_BIT;
         end
         itrd_pkg::ST_DIV_BIT: begin
            if (sts.bit_last) state_in = itrd_pkg::ST_DIV_STORE;
         end
         itrd_pkg::ST_DIV_STORE: begin
            if (sts.quot_zero || sts.cnt_full) begin
               state_in = itrd_pkg::ST_READ;
            end else begin
               state_in = itrd_pkg::ST_DIV_BIT;
            end
         end
         itrd_pkg::ST_READ: begin
            state_in = itrd_pkg::ST_LOAD_OUT;
         end
         itrd_pkg::ST_LOAD_OUT: begin
            if (sts.out_free) begin
               state_in = sts.cnt_one ? itrd_pkg::ST_IDLE : itrd_pkg::ST_READ;
            end
         end
         default: begin
            state_in = itrd_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         itrd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         itrd_pkg::ST_DIV_BIT:   cmd.step     = 1'b1;
         itrd_pkg::ST_DIV_STORE: cmd.store    = 1'b1;
         itrd_pkg::ST_READ:      cmd.read     = 1'b1;
         itrd_pkg::ST_LOAD_OUT:  cmd.load_out = sts.out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

[rtl/itrd_dp.sv]
// Datapath of the integer to radix digits block: radix register, bit-serial
// restoring divider, digit store and output register.
// Depends on itrd_pkg.
module itrd_dp #(
   parameter int VALUE_BITS = itrd_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [VALUE_BITS-1:0]        req_value,
   input  logic                         csr_write_enable,
   input  logic [itrd_pkg::BASE_W-1:0]  csr_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [itrd_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last_digit,
   input  itrd_pkg::itrd_cmd_type       cmd,
   output itrd_pkg::itrd_sts_type       sts
);

   localparam int IDX_W = $clog2(VALUE_BITS);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int BW    = itrd_pkg::BASE_W;

   logic [BW-1:0]         base_ff;
   logic [BW-1:0]         base_eff;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [BW-1:0]         rem_ff, rem_in;
   logic [BW:0]           rem_shift;
   logic                  qbit;
   logic [IDX_W-1:0]      bit_ff, bit_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      cnt_minus;
   logic [BW-1:0]         mem [VALUE_BITS];
   logic [BW-1:0]         rd_data_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [itrd_pkg::CHAR_W-1:0] out_char_ff;
   logic                  out_last_ff;

   // Radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= itrd_pkg::BASE_RESET;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   assign base_eff = itrd_pkg::effective_base(base_ff);

   // One restoring division step: bring down the next dividend bit
   assign rem_shift = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign qbit      = (rem_shift >= {1'b0, base_eff});

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      if (cmd.load) begin
         quot_in = req_value;
         rem_in  = '0;
         bit_in  = '0;
      end else if (cmd.step) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], qbit};
         rem_in  = qbit ? BW'(rem_shift - {1'b0, base_eff}) : rem_shift[BW-1:0];
         bit_in  = bit_ff + IDX_W'(1);
      end else if (cmd.store) begin
         rem_in  = '0;
         bit_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   // Digit count: counts up while dividing, down while emitting
   assign cnt_minus = cnt_ff - CNT_W'(1);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.store) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.load_out) begin
         cnt_in = cnt_minus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Digit store, registered read
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[cnt_ff[IDX_W-1:0]] <= rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[cnt_minus[IDX_W-1:0]];
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.load_out) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_char_ff <= itrd_pkg::digit_to_ascii(rd_data_ff);
         out_last_ff <= (cnt_ff == CNT_W'(1));
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last_digit = out_last_ff;

   // Status
   assign sts.bit_last  = (bit_ff == IDX_W'(VALUE_BITS - 1));
   assign sts.quot_zero = (quot_ff == '0);
   assign sts.cnt_full  = (cnt_ff == CNT_W'(VALUE_BITS - 1));
   assign sts.cnt_one   = (cnt_ff == CNT_W'(1));
   assign sts.out_free  = !out_valid_ff || !rsp_stall;

endmodule

[rtl/integer_to_radix_digits.sv]
// Integer to radix digits: converts a non-negative integer to ASCII digits
// in a base from 2 to 36, most significant digit first.
// Usage:
//   req_ channel: one item, req_value, taken when req_valid is high and
//   req_stall is low. req_stall stays high from acceptance until the last
//   digit has been loaded into the output register.
//   rsp_ channel: one item per digit, rsp_digit_char ('0'-'9', 'A'-'Z'),
//   rsp_last_digit set on the least significant digit.
//   csr_ port: csr_write_data is the radix, written when csr_write_enable
//   is high; 0 and 1 act as 2, 37 to 63 act as 36. Write only while idle.
// Flow: each digit is found by the bit-serial divider (one quotient bit per
//   cycle) and written to the digit store; once division ends, the digits
//   are read back from the store one at a time and loaded into the output
//   register.
// Stalls: a stalled result holds in the output register and emission
//   pauses; the next item may be accepted while the final digit waits.
// Reset (synchronous): radix returns to 10, controller to idle, no result
//   pending. The digit store is not cleared.
// Depends on itrd_pkg, itrd_ctrl, itrd_dp.
module integer_to_radix_digits #(
   parameter int VALUE_BITS = itrd_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [VALUE_BITS-1:0]        req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [itrd_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last_digit,
   input  logic                         csr_write_enable,
   input  logic [itrd_pkg::BASE_W-1:0]  csr_write_data
);

   itrd_pkg::itrd_cmd_type cmd;
   itrd_pkg::itrd_sts_type sts;

   itrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   itrd_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last_digit   (rsp_last_digit),
      .cmd              (cmd),
      .sts              (sts)
   );

   // Busy right after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted item did not make the block busy");

   // A pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("output register loaded over a stalled result");

   // At most one datapath command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.store, cmd.read, cmd.load_out}))
      else $error("conflicting datapath commands");

   // No result pending after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench for integer_to_radix_digits: drives values in several radix settings and checks
// every ASCII digit and last-digit flag against a digit predictor kept in step with the block.
// Depends on itrd_pkg and the block's RTL.
module tb;

   localparam int VALUE_W = itrd_pkg::DEFAULT_VALUE_BITS;
   localparam int BASE_W  = itrd_pkg::BASE_W;
   localparam int CHAR_W  = itrd_pkg::CHAR_W;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   typedef struct {
      logic [VALUE_W-1:0] value;
      bit                 drain_first;  // hold this item back until all digits are out
   } value_item_type;

   typedef struct {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } digit_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CHAR_W-1:0]   rsp_digit_char;
   logic                rsp_last_digit;
   logic                csr_write_enable = 1'b0;
   logic [BASE_W-1:0]   csr_write_data = '0;

   value_item_type pending_values[$];
   digit_item_type expected_digits[$];
   logic [BASE_W-1:0] radix_shadow = itrd_pkg::BASE_RESET;
   int  values_queued = 0;
   int  values_taken = 0;
   bit  req_taken = 1'b0;
   bit  failed = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  flow_left = 0;

   integer_to_radix_digits i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last_digit   (rsp_last_digit),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Split a value into digits of the clamped radix, queue them most significant first
   task automatic predict_digits(input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] reg_val);
      logic [BASE_W-1:0]  radix;
      logic [BASE_W-1:0]  digits[VALUE_W];
      logic [VALUE_W-1:0] rest;
      digit_item_type     d;
      int                 n;
      int                 k;
      radix = reg_val;
      if (reg_val < 6'd2) radix = 6'd2;
      else if (reg_val > 6'd36) radix = 6'd36;
      rest = v;
      n = 0;
      do begin
         digits[n] = BASE_W'(rest % radix);
         rest = rest / radix;
         n++;
      end while (rest != 0 && n < VALUE_W);
      for (k = n - 1; k >= 0; k--) begin
         if (digits[k] < 6'd10) d.digit_char = itrd_pkg::ASCII_ZERO + {1'b0, digits[k]};
         else d.digit_char = ASCII_UPPER_A + {1'b0, digits[k]} - 7'd10;
         d.last_digit = (k == 0);
         expected_digits = {expected_digits, d};
      end
   endtask

   // Random value: spread of lengths, full-width words, small values and edges
   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      int w;
      logic [VALUE_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         w = $urandom_range(1, VALUE_W);
         v = VALUE_W'($urandom);
         v = v & (VALUE_MAX >> (VALUE_W - w));
         v[w-1] = 1'b1;
      end else if (r < 70) begin
         v = VALUE_W'($urandom);
      end else if (r < 85) begin
         v = VALUE_W'($urandom_range(0, 75));
      end else if (r < 95) begin
         case ($urandom_range(0, 3))
            0: v = VALUE_MAX;
            1: v = VALUE_MAX >> 1;
            2: v = {1'b1, {(VALUE_W-1){1'b0}}};
            default: v = VALUE_MAX - VALUE_W'($urandom_range(0, 3));
         endcase
      end else begin
         v = '0;
      end
      return v;
   endfunction

   task automatic queue_value(input logic [VALUE_W-1:0] v, input bit drain);
      value_item_type it;
      it.value = v;
      it.drain_first = drain;
      pending_values = {pending_values, it};
      values_queued++;
   endtask

   // Wait on a falling edge until every item is taken and every digit is out
   task automatic wait_idle();
      @(negedge clock);
      while (values_taken != values_queued || expected_digits.size() != 0) @(negedge clock);
   endtask

   task automatic set_radix(input logic [BASE_W-1:0] b);
      wait_idle();
      csr_write_data   <= b;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(input logic [BASE_W-1:0] b, input int count);
      int i;
      set_radix(b);
      for (i = 0; i < count; i++) queue_value(pick_value(), ($urandom_range(0, 99) < 3));
   endtask

   // Request driver: holds a stalled item, otherwise gap or next value
   always @(negedge clock) begin
      value_item_type it;
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // stalled: payload stays as it is
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_values.size() != 0 &&
                      !(pending_values[0].drain_first && expected_digits.size() != 0)) begin
            it = pending_values.pop_front();
            req_valid <= 1'b1;
            req_value <= it.value;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall: runs of stall between stretches of free flow
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (flow_left > 0) begin
         rsp_stall <= 1'b0;
         flow_left--;
      end else begin
         rsp_stall <= 1'b0;
         flow_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 5);
         stall_left = pick_gap();
      end
   end

   // Monitor: predict on each taken value, check each taken digit
   always @(posedge clock) begin
      digit_item_type exp_d;
      req_taken = 1'b0;
      if (reset) begin
         radix_shadow = itrd_pkg::BASE_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            predict_digits(req_value, radix_shadow);
            values_taken++;
            req_taken = 1'b1;
         end
         if (csr_write_enable) radix_shadow = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected digit, actual char %0d last %0b",
                        $time, rsp_digit_char, rsp_last_digit);
               failed = 1'b1;
            end else begin
               exp_d = expected_digits.pop_front();
               if (rsp_digit_char !== exp_d.digit_char) begin
                  $display("%0t: digit_char expected %0d actual %0d",
                           $time, exp_d.digit_char, rsp_digit_char);
                  failed = 1'b1;
               end
               if (rsp_last_digit !== exp_d.last_digit) begin
                  $display("%0t: last_digit expected %0b actual %0b",
                           $time, exp_d.last_digit, rsp_last_digit);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // Stimulus sequence
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset radix (ten): zero, one digit, two digits, edges of the field
      queue_value('0, 0);
      queue_value(1, 0);
      queue_value(9, 0);
      queue_value(10, 0);
      queue_value(99999, 0);
      queue_value(VALUE_MAX, 0);
      queue_value({1'b1, {(VALUE_W-1){1'b0}}}, 0);

      // Base two, including the longest digit run
      set_radix(6'd2);
      queue_value('0, 0);
      queue_value(1, 0);
      queue_value(2, 0);
      queue_value(VALUE_MAX, 0);

      // Base thirty-six: the letter Z and two-digit boundaries
      set_radix(6'd36);
      queue_value(35, 0);
      queue_value(36, 0);
      queue_value(1295, 0);
      queue_value(VALUE_MAX, 1);

      // Register below two saturates to two
      set_radix(6'd0);
      queue_value(3, 0);
      queue_value(VALUE_W'({(VALUE_W/2+1){2'b01}}), 0);
      set_radix(6'd1);
      queue_value(2, 0);
      queue_value(5, 0);

      // Register above thirty-six saturates to thirty-six
      set_radix(6'd37);
      queue_value(35, 0);
      queue_value(36, 0);
      set_radix(6'd63);
      queue_value(VALUE_MAX, 0);
      queue_value(VALUE_W'({(VALUE_W/2+1){2'b10}}), 0);

      // Random part over a spread of radix settings
      random_phase(6'd2, 60);
      random_phase(6'd36, 60);
      random_phase(6'd16, 50);
      random_phase(BASE_W'($urandom_range(0, 63)), 55);
      random_phase(BASE_W'($urandom_range(3, 35)), 55);
      random_phase(6'd63, 55);
      random_phase(BASE_W'($urandom_range(0, 63)), 55);

      wait_idle();
      repeat (60) @(negedge clock);
      if (!failed && expected_digits.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Run limit
   initial begin
      #60_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

[filelist.f]
rtl/itrd_pkg.sv
rtl/itrd_ctrl.sv
rtl/itrd_dp.sv
rtl/integer_to_radix_digits.sv
dv/tb.sv
